// ===== hw/rtl/sat_pkg.sv =====
// Shared types and codes of the shell argument tokenizer.
`timescale 1ns / 1ps

package sat_pkg;

	// Result kind, carried on m_tuser
	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_END_ARG = 2'd1,
		KIND_END_CMD = 2'd2
	} kind_t;

	// One queued beat's worth of work: bytes first, then end of argument, then end of command
	typedef struct packed {
		logic [1:0] nbytes;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       end_arg;
		logic       end_cmd;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

// ===== hw/rtl/shell_argument_tokenizer_core.sv =====
// Top level of the shell argument tokenizer: front end, entry queue and back end.
// Results of an accepted beat are written to the queue, then loaded into the output register by the back end.
// Throughput: one input beat per cycle while the queue is not full; the back end issues one result
//   beat per cycle while the result stream is not stalled, so a beat gives bursts of up to 4 results.
// The QUEUE_DEPTH-entry queue absorbs those bursts; s_tready drops only when it is full.
// Reset: arst_n clears the quote/escape/argument state, queue pointers and output valid.
`timescale 1ns / 1ps

module shell_argument_tokenizer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic       s_tuser,  // [0] has_byte
	input  logic       s_tlast,  // end_of_command
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic [1:0] m_tuser,  // [1:0] kind
	output logic       m_tlast   // last result of the input beat
);
	import sat_pkg::*;

	entry_t        wr_entry;
	entry_t        head;
	logic          wr_en;
	logic          pop;
	queue_status_t qstat;
	kind_t         kind;

	// Front: classifies each beat and updates tokenizer state at accept
	sat_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.has_byte       (s_tuser),
		.data_byte      (s_tdata),
		.end_of_command (s_tlast),
		.queue_full     (qstat.full),
		.wr_en          (wr_en),
		.wr_entry       (wr_entry)
	);

	// Queue decouples front from a stalled result stream
	sat_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.status   (qstat)
	);

	// Back: one result beat per cycle from the queue head while the result stream is not stalled
	sat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.status    (qstat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (kind),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	assign m_tuser = kind;

endmodule

// ===== hw/rtl/sat_front.sv =====
// Front end: takes input beats, tracks quote and escape state, builds queue entries.
`timescale 1ns / 1ps

module sat_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            has_byte,
	input  logic [7:0]      data_byte,
	input  logic            end_of_command,
	input  logic            queue_full,
	output logic            wr_en,
	output sat_pkg::entry_t wr_entry
);
	import sat_pkg::*;

	typedef enum logic [1:0] {
		Q_NONE   = 2'd0,
		Q_DOUBLE = 2'd1,
		Q_SINGLE = 2'd2
	} quote_t;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_V      = 8'h76;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	logic   in_arg_q;
	quote_t quote_q;
	logic   esc_q;

	logic   in_arg_d;
	quote_t quote_d;
	logic   esc_d;
	entry_t ent;
	logic   accept;

	function automatic logic is_blank(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_VT ||
		       ch == CH_FF || ch == CH_CR;
	endfunction

	always_comb begin
		quote_t q;
		logic   handled;
		in_arg_d = in_arg_q;
		quote_d  = quote_q;
		esc_d    = esc_q;
		ent      = '0;
		handled  = 1'b0;
		q        = (data_byte == CH_DQUOTE) ? Q_DOUBLE :
		           (data_byte == CH_SQUOTE) ? Q_SINGLE : Q_NONE;
		if (has_byte && (in_arg_d || !is_blank(data_byte))) begin
			if (!in_arg_d) begin
				in_arg_d = 1'b1;
				quote_d  = Q_NONE;
				esc_d    = 1'b0;
			end
			// quote open/close leaves the escape flag alone
			if (q != Q_NONE) begin
				if (quote_d == Q_NONE) begin
					quote_d = q;
					handled = 1'b1;
				end else if (quote_d == q) begin
					quote_d = Q_NONE;
					handled = 1'b1;
				end
			end else if (data_byte == CH_BSL && !esc_d) begin
				esc_d   = 1'b1;
				handled = 1'b1;
			end
			if (!handled) begin
				if (is_blank(data_byte) && quote_d == Q_NONE && !esc_d) begin
					in_arg_d    = 1'b0;
					ent.end_arg = 1'b1;
				end else if (quote_d != Q_NONE && esc_d) begin
					ent.nbytes = 2'd1;
					unique case (data_byte) inside
						CH_F: ent.b0 = CH_FF;
						CH_N: ent.b0 = CH_LF;
						CH_R: ent.b0 = CH_CR;
						CH_T: ent.b0 = CH_TAB;
						CH_V: ent.b0 = CH_VT;
						CH_DQUOTE, CH_SQUOTE, CH_BSL: ent.b0 = data_byte;
						default: begin
							// unknown escape keeps its backslash
							ent.nbytes = 2'd2;
							ent.b0     = CH_BSL;
							ent.b1     = data_byte;
						end
					endcase
					esc_d = 1'b0;
				end else begin
					ent.nbytes = 2'd1;
					ent.b0     = data_byte;
					esc_d      = 1'b0;
				end
			end
		end
		if (end_of_command) begin
			if (in_arg_d) begin
				ent.end_arg = 1'b1;
			end
			ent.end_cmd = 1'b1;
			in_arg_d    = 1'b0;
			quote_d     = Q_NONE;
			esc_d       = 1'b0;
		end
	end

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign wr_en    = accept && (ent.nbytes != 2'd0 || ent.end_arg || ent.end_cmd);
	assign wr_entry = ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arg_q <= 1'b0;
			quote_q  <= Q_NONE;
			esc_q    <= 1'b0;
		end else if (accept) begin
			in_arg_q <= in_arg_d;
			quote_q  <= quote_d;
			esc_q    <= esc_d;
		end
	end

endmodule

// ===== hw/rtl/sat_queue.sv =====
// Small register FIFO of work entries between front and back.
`timescale 1ns / 1ps

module sat_queue #(
	parameter int DEPTH = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  sat_pkg::entry_t        wr_entry,
	input  logic                   pop,
	output sat_pkg::entry_t        rd_entry,
	output sat_pkg::queue_status_t status
);
	import sat_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign status.full  = count_q == CNT_W'(DEPTH);
	assign status.empty = count_q == '0;
	assign rd_entry     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr_en && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !status.full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty) else $error("queue popped while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count out of range");

endmodule

// ===== hw/rtl/sat_back.sv =====
// Back end: unrolls queued entries into result beats through an output register.
`timescale 1ns / 1ps

module sat_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sat_pkg::entry_t        head,
	input  sat_pkg::queue_status_t status,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_ready,
	output sat_pkg::kind_t         out_kind,
	output logic [7:0]             out_byte,
	output logic                   out_last
);
	import sat_pkg::*;

	logic [1:0] idx_q;
	logic       out_valid_q;
	kind_t      out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;

	logic [2:0] n_res;
	logic       load;
	logic       res_last;
	kind_t      res_kind;
	logic [7:0] res_byte;

	assign n_res    = 3'(head.nbytes) + 3'(head.end_arg) + 3'(head.end_cmd);
	assign res_last = {1'b0, idx_q} == (n_res - 3'd1);
	assign load     = !status.empty && (!out_valid_q || out_ready);
	assign pop      = load && res_last;

	always_comb begin
		res_byte = 8'h00;
		if (idx_q < head.nbytes) begin
			res_kind = KIND_BYTE;
			res_byte = idx_q[0] ? head.b1 : head.b0;
		end else if (idx_q == head.nbytes && head.end_arg) begin
			res_kind = KIND_END_ARG;
		end else begin
			res_kind = KIND_END_CMD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= res_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_kind_q <= res_kind;
			out_byte_q <= res_byte;
			out_last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	a_mid_entry_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !status.empty) else $error("entry lost mid-way");
	a_entry_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!status.empty |-> (head.nbytes != 2'd0 || head.end_arg || head.end_cmd))
		else $error("empty entry queued");
	a_end_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_END_CMD |-> out_last_q)
		else $error("end of command not last");
	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q != KIND_BYTE |-> out_byte_q == 8'h00)
		else $error("marker beat carries a byte");

endmodule

// ===== tb/tokenizer_checker.sv =====
// Checker for the shell argument tokenizer: predicts each beat's results and compares.
`timescale 1ns / 1ps

module tokenizer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic [1:0] m_tuser,
	input  logic       m_tlast,
	output int         fails,
	output int         pending
);
	import sat_pkg::*;

	typedef enum logic [1:0] {
		QUOTE_NONE   = 2'd0,
		QUOTE_DOUBLE = 2'd1,
		QUOTE_SINGLE = 2'd2
	} quote_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       last;
	} token_t;

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_V  = 8'h76;

	logic   in_word;
	quote_t quote_open;
	logic   escape_armed;
	int     results_seen;

	token_t expected_tokens[$];
	token_t beat_tokens[$];

	function automatic logic is_blank(logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_VT ||
			ch == CH_FF || ch == CH_CR;
	endfunction

	function automatic void add_token(kind_t k, logic [7:0] d);
		token_t t;
		t.kind = k;
		t.data = d;
		t.last = 1'b0;
		beat_tokens = {beat_tokens, t};
	endfunction

	// one byte while a word is open
	function automatic void split_char(logic [7:0] ch);
		quote_t q;
		q = (ch == CH_DQUOTE) ? QUOTE_DOUBLE :
			(ch == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_NONE;
		// opening or closing quote leaves the escape as it stands
		if (q != QUOTE_NONE && quote_open == QUOTE_NONE) begin
			quote_open = q;
			return;
		end
		if (q != QUOTE_NONE && quote_open == q) begin
			quote_open = QUOTE_NONE;
			return;
		end
		if (q == QUOTE_NONE && ch == CH_BSLASH && !escape_armed) begin
			escape_armed = 1'b1;
			return;
		end
		if (is_blank(ch) && quote_open == QUOTE_NONE && !escape_armed) begin
			in_word = 1'b0;
			add_token(KIND_END_ARG, 8'h00);
			return;
		end
		if (quote_open != QUOTE_NONE && escape_armed) begin
			case (ch)
				CH_LOW_F: add_token(KIND_BYTE, CH_FF);
				CH_LOW_N: add_token(KIND_BYTE, CH_LF);
				CH_LOW_R: add_token(KIND_BYTE, CH_CR);
				CH_LOW_T: add_token(KIND_BYTE, CH_TAB);
				CH_LOW_V: add_token(KIND_BYTE, CH_VT);
				CH_DQUOTE, CH_SQUOTE, CH_BSLASH: add_token(KIND_BYTE, ch);
				default: begin
					add_token(KIND_BYTE, CH_BSLASH);
					add_token(KIND_BYTE, ch);
				end
			endcase
		end else begin
			add_token(KIND_BYTE, ch);
		end
		escape_armed = 1'b0;
	endfunction

	function automatic void tokenize_beat(logic has, logic [7:0] ch, logic eoc);
		beat_tokens.delete();
		if (has) begin
			if (in_word) begin
				split_char(ch);
			end else if (!is_blank(ch)) begin
				in_word = 1'b1;
				quote_open = QUOTE_NONE;
				escape_armed = 1'b0;
				split_char(ch);
			end
		end
		if (eoc) begin
			if (in_word)
				add_token(KIND_END_ARG, 8'h00);
			add_token(KIND_END_CMD, 8'h00);
			in_word = 1'b0;
			quote_open = QUOTE_NONE;
			escape_armed = 1'b0;
		end
		if (beat_tokens.size() > 0)
			beat_tokens[beat_tokens.size() - 1].last = 1'b1;
		expected_tokens = {expected_tokens, beat_tokens};
	endfunction

	function automatic void note_fail(string what, token_t want, token_t got);
		if (fails < 10)
			$display("%0t: result %0d %s: expected kind %0d byte %02h last %b, %s",
				$time, results_seen, what, want.kind, want.data, want.last,
				$sformatf("got kind %0d byte %02h last %b",
					got.kind, got.data, got.last));
		fails++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		token_t got;
		token_t want;
		if (!arst_n) begin
			in_word = 1'b0;
			quote_open = QUOTE_NONE;
			escape_armed = 1'b0;
			expected_tokens.delete();
			fails = 0;
			pending = 0;
			results_seen = 0;
		end else begin
			// outputs first: a beat accepted at this edge cannot have answered yet
			if (m_tvalid && m_tready) begin
				got.kind = kind_t'(m_tuser);
				got.data = m_tdata;
				got.last = m_tlast;
				if (expected_tokens.size() == 0) begin
					note_fail("with nothing expected", '0, got);
				end else begin
					want = expected_tokens.pop_front();
					if (got !== want)
						note_fail("differs", want, got);
				end
				results_seen++;
			end
			if (s_tvalid && s_tready)
				tokenize_beat(s_tuser, s_tdata, s_tlast);
			pending = expected_tokens.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top of the shell argument tokenizer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

	localparam int HOLD_CYCLES   = 60;   // long receiver hold-off to fill the entry queue
	localparam int RANDOM_BEATS  = 300;  // beats that do something, random part
	localparam int DRAIN_CYCLES  = 16;   // drain time after the checker has nothing pending

	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] data_byte
	logic       s_tuser;   // [0] has_byte
	logic       s_tlast;   // end_of_command
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_byte
	logic [1:0] m_tuser;   // [1:0] kind
	logic       m_tlast;   // last result of the input beat

	int fails;
	int pending;

	// quiet_run: neither side idles for the current command line
	// hold_request: ask the receiver for one long hold-off
	bit quiet_run;
	bit hold_request;
	int useful_beats;

	shell_argument_tokenizer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	tokenizer_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.fails    (fails),
		.pending  (pending)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Hard stop; the slowest correct run is well under a tenth of this.
	initial begin
		#200000;
		$display("Mismatches found");
		$finish;
	end

	// Receiver: per beat a random stall (none in a quiet run), or a long hold-off on request.
	// Everything moves on the falling edge; handshakes are seen at the rising edge.
	initial begin : receiver
		int stall;
		m_tready = 1'b0;
		@(negedge clk);
		while (!arst_n)
			@(negedge clk);
		forever begin
			if (hold_request) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end
			stall = quiet_run ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// One input beat: optional gap with tvalid low, then offer until taken.
	// Returns on the falling edge after acceptance with tvalid still high,
	// so back-to-back beats keep it high.
	task automatic send_beat(input logic has, input logic [7:0] ch, input logic eoc);
		int gap;
		gap = quiet_run ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = has;
		s_tdata  = ch;
		s_tlast  = eoc;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (has || eoc)
			useful_beats++;
	endtask

	// Bytes weighted towards the ones the tokenizer treats specially
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
			3: begin
				case ($urandom_range(0, 5))
					0: return CH_SPACE;
					1: return CH_TAB;
					2: return CH_LF;
					3: return CH_VT;
					4: return CH_FF;
					default: return CH_CR;
				endcase
			end
			4: return CH_DQUOTE;
			5: return CH_SQUOTE;
			6: return CH_BSLASH;
			7: begin
				case ($urandom_range(0, 4))
					0: return "f";
					1: return "n";
					2: return "r";
					3: return "t";
					default: return "v";
				endcase
			end
			8: return 8'($urandom_range(0, 255));
			default: return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(128, 255));
		endcase
	endfunction

	// A well-formed command line: bytes, then a beat marked as its end
	task automatic send_command();
		int n;
		n = $urandom_range(1, 12);
		quiet_run = ($urandom_range(0, 4) == 0);
		for (int i = 0; i < n - 1; i++)
			send_beat(1'b1, pick_char(), 1'b0);
		// end marker mostly rides on a byte, sometimes stands alone
		send_beat($urandom_range(0, 5) != 0, pick_char(), 1'b1);
	endtask

	// Raw beats: empty markers, stray ends, any byte
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		quiet_run = 1'b0;
		for (int i = 0; i < n; i++)
			send_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
				$urandom_range(0, 3) == 0);
	endtask

	initial begin : stimulus
		int commands;
		s_tvalid     = 1'b0;
		s_tdata      = 8'h00;
		s_tuser      = 1'b0;
		s_tlast      = 1'b0;
		quiet_run    = 1'b0;
		hold_request = 1'b0;
		useful_beats = 0;
		commands     = 0;
		arst_n       = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed part
		send_beat(1'b1, CH_SPACE, 1'b0);   // leading blank, skipped
		send_beat(1'b1, 8'h00, 1'b0);      // zero byte is ordinary, opens a word
		send_beat(1'b1, 8'hFF, 1'b0);
		send_beat(1'b1, CH_TAB, 1'b0);     // ends the word
		send_beat(1'b1, CH_LF, 1'b0);      // run of blanks, skipped
		send_beat(1'b1, CH_DQUOTE, 1'b0);  // quotes only: empty word
		send_beat(1'b1, CH_DQUOTE, 1'b0);
		send_beat(1'b1, CH_VT, 1'b0);
		send_beat(1'b1, CH_DQUOTE, 1'b0);
		send_beat(1'b1, CH_BSLASH, 1'b0);
		send_beat(1'b1, "n", 1'b0);        // escaped n in quotes -> line feed
		send_beat(1'b1, CH_SQUOTE, 1'b0);  // other quote kind is a plain byte
		send_beat(1'b1, CH_CR, 1'b0);      // blank inside quotes is kept
		send_beat(1'b1, CH_BSLASH, 1'b0);
		send_beat(1'b1, CH_DQUOTE, 1'b0);  // escaped closing quote still closes
		send_beat(1'b1, "x", 1'b0);        // escape carried out of the quotes
		send_beat(1'b1, CH_BSLASH, 1'b0);
		send_beat(1'b1, CH_BSLASH, 1'b0);  // double backslash
		send_beat(1'b1, CH_FF, 1'b0);
		send_beat(1'b0, 8'hA5, 1'b0);      // empty marker, no result
		send_beat(1'b0, 8'h5A, 1'b1);      // end with no word open
		send_beat(1'b1, CH_SQUOTE, 1'b0);
		send_beat(1'b1, CH_BSLASH, 1'b0);
		send_beat(1'b1, "q", 1'b1);        // four results from one beat
		send_beat(1'b1, CH_BSLASH, 1'b1);  // pending escape dropped at the end

		// Random part; every so often the receiver holds off while we flood
		useful_beats = 0;
		while (useful_beats < RANDOM_BEATS) begin
			if (commands % 30 == 0)
				hold_request = 1'b1;
			if ($urandom_range(0, 6) == 0) begin
				send_noise();
			end else begin
				send_command();
				commands++;
			end
		end
		s_tvalid  = 1'b0;
		quiet_run = 1'b0;

		do @(negedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
